// ===== rtl/pdh_pkg.sv =====
package pdh_pkg;

  localparam int INTEGRAL_BITS_DFLT = 48;
  localparam int QUEUE_DEPTH_DFLT   = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic signed [31:0] position_t;
  typedef logic signed [23:0] heading_t;
  typedef logic signed [23:0] distance_t;
  typedef logic signed [31:0] gain_t;
  typedef logic        [14:0] q15_mag_t;
  typedef logic signed [15:0] speed_t;
  typedef logic signed [63:0] sum_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEG_GAIN      = 3'd1,
    REG_DERIV_GAIN      = 3'd2,
    REG_SPEED_CEILING   = 3'd3,
    REG_SPEED_FLOOR     = 3'd4,
    REG_HEADING_HOLD_ON = 3'd5,
    REG_HEADING_GAIN    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    gain_t    prop_gain;
    gain_t    integ_gain;
    gain_t    deriv_gain;
    q15_mag_t speed_ceiling;
    q15_mag_t speed_floor;
    logic     heading_hold_on;
    gain_t    heading_gain;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_FINISHED,
    KIND_CONTROL
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t        kind;
    logic signed [31:0] err;
    logic signed [32:0] deriv;
    logic signed [24:0] hdiff;
  } entry_t;

  localparam gain_t    PROP_GAIN_RESET    = 32'sd21475;
  localparam gain_t    INTEG_GAIN_RESET   = 32'sd0;
  localparam gain_t    DERIV_GAIN_RESET   = -32'sd4295;
  localparam q15_mag_t CEILING_RESET      = 15'h7FFF;
  localparam q15_mag_t FLOOR_RESET        = 15'h0000;
  localparam gain_t    HEADING_GAIN_RESET = 32'sd429497;

  localparam logic signed [22:0] DPI_Q16 = 23'sd2730863;
  localparam position_t POS_MAX = 32'sh7FFF_FFFF;
  localparam position_t POS_MIN = 32'sh8000_0000;
  localparam int DONE_LIMIT   = 100;
  localparam int INTEG_WINDOW = 25000;
  localparam int DEAD_BAND    = 1638;
  localparam int TURN_LIMIT   = 32767;
  localparam sum_t SUM_LIMIT  = 64'sh4000_0000_0000_0000;

  function automatic sum_t sat_sum(input logic signed [65:0] v);
    logic signed [65:0] lim;
    lim = 66'(SUM_LIMIT);
    if (v > lim) begin
      return SUM_LIMIT;
    end else if (v < -lim) begin
      return -SUM_LIMIT;
    end else begin
      return v[63:0];
    end
  endfunction

endpackage

// ===== rtl/pdh_in_if.sv =====
interface pdh_in_if;
  import pdh_pkg::*;

  logic      valid;
  logic      ready;
  logic      mode;
  position_t wheel_position;
  heading_t  heading;
  distance_t distance;

  modport source(output valid, mode, wheel_position, heading, distance, input ready);
  modport sink(input valid, mode, wheel_position, heading, distance, output ready);
endinterface

// ===== rtl/pdh_out_if.sv =====
interface pdh_out_if;
  import pdh_pkg::*;

  logic   valid;
  logic   ready;
  speed_t drive_speed;
  speed_t turn_command;
  logic   done_res;

  modport source(output valid, drive_speed, turn_command, done_res, input ready);
  modport sink(input valid, drive_speed, turn_command, done_res, output ready);
endinterface

// ===== rtl/pdh_cfg_if.sv =====
interface pdh_cfg_if;
  import pdh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/pid_distance_drive_with_heading_hold.sv =====
// An accepted sample word is queued, then passes the product, saturated term, partial sum and
// full sum registers and the output register. Throughput is one word per cycle while the queue
// has room; the front updates the loop state in the cycle of acceptance.
// The queue between front and back holds QUEUE_DEPTH words while the output is stalled.
// Synchronous reset loads the register defaults, clears the loop state and empties the pipe.
module pid_distance_drive_with_heading_hold #(
  parameter int INTEGRAL_BITS = pdh_pkg::INTEGRAL_BITS_DFLT,
  parameter int QUEUE_DEPTH   = pdh_pkg::QUEUE_DEPTH_DFLT
) (
  input logic       clk,
  input logic       rst,
  pdh_in_if.sink    sample,
  pdh_out_if.source result,
  pdh_cfg_if.sink   cfg
);
  import pdh_pkg::*;

  localparam int ENTRY_W = $bits(entry_t) + INTEGRAL_BITS;

  cfg_t                            regs;
  logic                            take;
  logic                            q_full;
  logic                            q_valid;
  logic                            q_pop;
  entry_t                          f_entry;
  logic signed [INTEGRAL_BITS-1:0] f_integ;
  logic [ENTRY_W-1:0]              q_data;
  entry_t                          b_entry;
  logic signed [INTEGRAL_BITS-1:0] b_integ;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !q_full;
  assign take         = sample.valid && sample.ready;
  assign {b_entry, b_integ} = q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain       <= PROP_GAIN_RESET;
      regs.integ_gain      <= INTEG_GAIN_RESET;
      regs.deriv_gain      <= DERIV_GAIN_RESET;
      regs.speed_ceiling   <= CEILING_RESET;
      regs.speed_floor     <= FLOOR_RESET;
      regs.heading_hold_on <= 1'b1;
      regs.heading_gain    <= HEADING_GAIN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_PROP_GAIN:       regs.prop_gain       <= $signed(cfg.data);
        REG_INTEG_GAIN:      regs.integ_gain      <= $signed(cfg.data);
        REG_DERIV_GAIN:      regs.deriv_gain      <= $signed(cfg.data);
        REG_SPEED_CEILING:   regs.speed_ceiling   <= cfg.data[14:0];
        REG_SPEED_FLOOR:     regs.speed_floor     <= cfg.data[14:0];
        REG_HEADING_HOLD_ON: regs.heading_hold_on <= cfg.data[0];
        REG_HEADING_GAIN:    regs.heading_gain    <= $signed(cfg.data);
        default: begin
        end
      endcase
    end
  end

  pdh_front #(
    .INTEGRAL_BITS(INTEGRAL_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .mode           (sample.mode),
    .wheel_position (sample.wheel_position),
    .heading        (sample.heading),
    .distance       (sample.distance),
    .integ_on       (regs.integ_gain != '0),
    .entry          (f_entry),
    .integ          (f_integ)
  );

  pdh_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_data  ({f_entry, f_integ}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  pdh_back #(
    .INTEGRAL_BITS(INTEGRAL_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .in_valid (q_valid),
    .entry    (b_entry),
    .integ    (b_integ),
    .pop      (q_pop),
    .result   (result)
  );

  a_done_is_stopped: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.done_res |-> result.drive_speed == '0 && result.turn_command == '0)
    else $error("finished word carries a nonzero command");

  a_command_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.drive_speed != 16'sh8000 && result.turn_command != 16'sh8000)
    else $error("command outside the Q15 range");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> $past(result.valid && !result.ready))
    else $error("input stalled without output backpressure");

endmodule

// ===== rtl/pdh_front.sv =====
module pdh_front #(
  parameter int INTEGRAL_BITS = pdh_pkg::INTEGRAL_BITS_DFLT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            mode,
  input  pdh_pkg::position_t              wheel_position,
  input  pdh_pkg::heading_t               heading,
  input  pdh_pkg::distance_t              distance,
  input  logic                            integ_on,
  output pdh_pkg::entry_t                 entry,
  output logic signed [INTEGRAL_BITS-1:0] integ
);
  import pdh_pkg::*;

  localparam int IW = INTEGRAL_BITS + 1;
  localparam logic signed [IW-1:0] INTEG_MAX = $signed({2'b00, {(INTEGRAL_BITS-1){1'b1}}});
  localparam logic signed [IW-1:0] INTEG_MIN = $signed({2'b11, {(INTEGRAL_BITS-1){1'b0}}});

  position_t                       target_cdeg;
  position_t                       start_position;
  heading_t                        start_heading;
  position_t                       previous_error;
  position_t                       check_error;
  logic signed [INTEGRAL_BITS-1:0] integral_sum;

  logic signed [45:0] scaled;
  position_t          target_next;
  logic signed [33:0] remaining;
  position_t          err;
  logic               finished;
  logic signed [IW-1:0] integ_sum_ext;
  logic signed [IW-1:0] integ_acc;

  always_comb begin
    scaled      = distance * DPI_Q16;
    target_next = 32'((scaled + 46'sd32768) >>> 16);
    remaining   = 34'(target_cdeg) - (34'(wheel_position) - 34'(start_position));
    if (remaining > 34'(POS_MAX)) begin
      err = POS_MAX;
    end else if (remaining < 34'(POS_MIN)) begin
      err = POS_MIN;
    end else begin
      err = 32'(remaining);
    end
    finished = check_error <= DONE_LIMIT;

    // With integ_on, the integral sums only inside the window and clears outside it.
    integ_sum_ext = IW'(integral_sum) + IW'(err);
    if (integ_on) begin
      if (err < INTEG_WINDOW && err > -INTEG_WINDOW) begin
        if (integ_sum_ext > INTEG_MAX) begin
          integ_acc = INTEG_MAX;
        end else if (integ_sum_ext < INTEG_MIN) begin
          integ_acc = INTEG_MIN;
        end else begin
          integ_acc = integ_sum_ext;
        end
      end else begin
        integ_acc = '0;
      end
    end else begin
      integ_acc = IW'(integral_sum);
    end
    // A sum whose sign is opposite to that of a nonzero error is negated to match it.
    if ((integ_acc > 0 && err < 0) || (integ_acc < 0 && err > 0)) begin
      integ_acc = (integ_acc == INTEG_MIN) ? INTEG_MAX : -integ_acc;
    end
    integ = INTEGRAL_BITS'(integ_acc);

    if (!mode) begin
      entry.kind = KIND_START;
    end else if (finished) begin
      entry.kind = KIND_FINISHED;
    end else begin
      entry.kind = KIND_CONTROL;
    end
    entry.err   = err;
    entry.deriv = 33'(previous_error) - 33'(err);
    entry.hdiff = 25'(start_heading) - 25'(heading);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_cdeg    <= '0;
      start_position <= '0;
      start_heading  <= '0;
      previous_error <= '0;
      check_error    <= '0;
      integral_sum   <= '0;
    end else if (take) begin
      if (!mode) begin
        target_cdeg    <= target_next;
        start_position <= wheel_position;
        start_heading  <= heading;
        previous_error <= '0;
        check_error    <= target_next;
        integral_sum   <= '0;
      end else if (!finished) begin
        previous_error <= err;
        check_error    <= err;
        integral_sum   <= integ;
      end
    end
  end

endmodule

// ===== rtl/pdh_queue.sv =====
module pdh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pdh_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  import pdh_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full       = count == COUNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pdh_back.sv =====
module pdh_back #(
  parameter int INTEGRAL_BITS = pdh_pkg::INTEGRAL_BITS_DFLT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pdh_pkg::cfg_t                   regs,
  input  logic                            in_valid,
  input  pdh_pkg::entry_t                 entry,
  input  logic signed [INTEGRAL_BITS-1:0] integ,
  output logic                            pop,
  pdh_out_if.source                       result
);
  import pdh_pkg::*;

  localparam int PW = INTEGRAL_BITS + 32;
  localparam logic signed [PW-1:0] PROD_MAX = PW'(SUM_LIMIT);
  localparam logic signed [PW-1:0] PROD_MIN = -PROD_MAX;

  logic adv;
  logic v1, v2, v3, v4;
  entry_kind_t k1, k2, k3, k4;

  logic signed [63:0]              p1;
  logic signed [64:0]              d1;
  logic signed [64:0]              il1;
  logic signed [INTEGRAL_BITS-1:0] ih1;
  logic signed [56:0]              h1;

  sum_t   p2, d2, i2, s3, d3, s4;
  speed_t t2, t3, t4;

  logic signed [PW-1:0] i_full;
  sum_t                 i_sat;
  logic signed [39:0]   h_shift;
  speed_t               turn_next;
  logic signed [46:0]   dr;
  logic signed [46:0]   ceil_w;
  logic signed [46:0]   floor_w;
  speed_t               drive_next;

  assign adv = !result.valid || result.ready;
  assign pop = adv && in_valid;

  always_comb begin
    i_full = (PW'(ih1) <<< 32) + PW'(il1);
    if (i_full > PROD_MAX) begin
      i_sat = SUM_LIMIT;
    end else if (i_full < PROD_MIN) begin
      i_sat = -SUM_LIMIT;
    end else begin
      i_sat = 64'(i_full);
    end

    h_shift = 40'(h1 >>> 17);
    if (h_shift > TURN_LIMIT) begin
      h_shift = 40'(TURN_LIMIT);
    end else if (h_shift < -TURN_LIMIT) begin
      h_shift = -40'(TURN_LIMIT);
    end
    turn_next = regs.heading_hold_on ? 16'(-h_shift) : '0;

    ceil_w  = $signed(47'(regs.speed_ceiling));
    floor_w = $signed(47'(regs.speed_floor));
    dr      = 47'(s4 >>> 17);
    if (dr > ceil_w) begin
      dr = ceil_w;
    end
    if (dr < -ceil_w) begin
      dr = -ceil_w;
    end
    if (dr < DEAD_BAND && dr > -DEAD_BAND) begin
      dr = '0;
    end else if (dr > 0 && dr < floor_w) begin
      dr = floor_w;
    end else if (dr < 0 && dr > -floor_w) begin
      dr = -floor_w;
    end
    drive_next = 16'(dr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      v1           <= in_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1  <= entry.kind;
      p1  <= $signed(entry.err) * regs.prop_gain;
      d1  <= $signed(entry.deriv) * regs.deriv_gain;
      il1 <= $signed({1'b0, integ[31:0]}) * regs.integ_gain;
      ih1 <= $signed(integ[INTEGRAL_BITS-1:32]) * regs.integ_gain;
      h1  <= $signed(entry.hdiff) * regs.heading_gain;

      k2 <= k1;
      p2 <= sat_sum(66'(p1));
      d2 <= sat_sum(66'(d1));
      i2 <= i_sat;
      t2 <= turn_next;

      k3 <= k2;
      s3 <= sat_sum(66'(p2) + 66'(i2));
      d3 <= d2;
      t3 <= t2;

      k4 <= k3;
      s4 <= sat_sum(66'(s3) + 66'(d3));
      t4 <= t3;

      result.drive_speed  <= (k4 == KIND_CONTROL) ? drive_next : '0;
      result.turn_command <= (k4 == KIND_CONTROL) ? t4 : '0;
      result.done_res     <= k4 == KIND_FINISHED;
    end
  end

endmodule
